@@ rtl/cbbsu_pkg.sv @@
package cbbsu_pkg;

    localparam int unsigned NUM_REGS = 7;

    // operand / load index codes
    localparam logic [2:0] OPND_MEM   = 3'd6;
    localparam logic [2:0] OPND_A     = 3'd7;
    localparam logic [2:0] LOAD_FLAGS = 3'd6;

    // register file slots
    localparam logic [2:0] SLOT_H = 3'd4;
    localparam logic [2:0] SLOT_L = 3'd5;
    localparam logic [2:0] SLOT_A = 3'd6;

    typedef enum logic [1:0] {
        GRP_SHIFT = 2'd0,
        GRP_BIT   = 2'd1,
        GRP_RES   = 2'd2,
        GRP_SET   = 2'd3
    } t_group;

    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } t_shift;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    function automatic logic [2:0] slot_of(input logic [2:0] idx);
        return (idx == OPND_A) ? SLOT_A : idx;
    endfunction

endpackage

@@ rtl/cbbsu_alu.sv @@
module cbbsu_alu (
    input  logic [7:0]      i_opcode,
    input  logic [7:0]      i_operand,
    input  cbbsu_pkg::t_flags i_flags,
    output logic [7:0]      o_result,
    output cbbsu_pkg::t_flags o_flags,
    output logic            o_writes
);

    logic [2:0] sub;
    logic [7:0] mask;
    logic [7:0] sh_res;
    logic       sh_c;

    assign sub  = i_opcode[5:3];
    assign mask = 8'(1) << sub;

    always_comb begin
        unique case (cbbsu_pkg::t_shift'(sub))
            cbbsu_pkg::SH_RLC: begin
                sh_c   = i_operand[7];
                sh_res = {i_operand[6:0], i_operand[7]};
            end
            cbbsu_pkg::SH_RRC: begin
                sh_c   = i_operand[0];
                sh_res = {i_operand[0], i_operand[7:1]};
            end
            cbbsu_pkg::SH_RL: begin
                sh_c   = i_operand[7];
                sh_res = {i_operand[6:0], i_flags.c};
            end
            cbbsu_pkg::SH_RR: begin
                sh_c   = i_operand[0];
                sh_res = {i_flags.c, i_operand[7:1]};
            end
            cbbsu_pkg::SH_SLA: begin
                sh_c   = i_operand[7];
                sh_res = {i_operand[6:0], 1'b0};
            end
            cbbsu_pkg::SH_SRA: begin
                sh_c   = i_operand[0];
                sh_res = {i_operand[7], i_operand[7:1]};
            end
            cbbsu_pkg::SH_SWAP: begin
                sh_c   = 1'b0;
                sh_res = {i_operand[3:0], i_operand[7:4]};
            end
            default: begin
                sh_c   = i_operand[0];
                sh_res = {1'b0, i_operand[7:1]};
            end
        endcase
    end

    always_comb begin
        o_flags  = i_flags;
        o_writes = 1'b1;
        unique case (cbbsu_pkg::t_group'(i_opcode[7:6]))
            cbbsu_pkg::GRP_SHIFT: begin
                o_result  = sh_res;
                o_flags.z = (sh_res == 8'd0);
                o_flags.n = 1'b0;
                o_flags.h = 1'b0;
                o_flags.c = sh_c;
            end
            cbbsu_pkg::GRP_BIT: begin
                o_result  = i_operand;
                o_writes  = 1'b0;
                o_flags.z = ~i_operand[sub];
                o_flags.n = 1'b0;
                o_flags.h = 1'b1;
            end
            cbbsu_pkg::GRP_RES: o_result = i_operand & ~mask;
            default:            o_result = i_operand | mask;
        endcase
    end

endmodule

@@ rtl/cb_prefix_bit_shift_unit.sv @@
// CB-page bit/shift execution unit with its own B,C,D,E,H,L,A file and Z/N/H/C flags.
// Input channel (i_in_valid/o_in_ready) takes one beat per item: either a CB
// opcode to execute (i_command = 0) or a register/flags load (i_command = 1).
// For operand (HL) the caller supplies the byte at H:L on i_mem_read_data; the
// write-back comes out as o_mem_write/o_mem_write_data with o_mem_address.
// Output channel (o_out_valid/i_out_ready) returns exactly one beat per item.
// A beat accepted into the input register is computed from it and lands in the
// result register when the stage advances; o_out_valid rises after that edge.
// Throughput: one item per cycle while i_out_ready stays high, set by the single
// compute stage between the input and result registers; the register file is
// updated as the result is registered, so the next item sees it without a bubble.
// Receiver stall: the result register holds, the input register holds one more
// item, then o_in_ready drops until the result is taken.
// Reset: registers and flags clear to zero, both stages empty.
module cb_prefix_bit_shift_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_mem_read_data,
    input  logic [2:0]  i_load_index,
    input  logic [7:0]  i_load_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_result_value,
    output logic [3:0]  o_flags_out,
    output logic        o_mem_write,
    output logic [15:0] o_mem_address,
    output logic [7:0]  o_mem_write_data
);

    // input stage
    logic       r_in_vld;
    logic       r_command;
    logic [7:0] r_opcode;
    logic [7:0] r_mem_rd;
    logic [2:0] r_load_index;
    logic [7:0] r_load_value;

    // state
    logic [7:0]        r_regs [cbbsu_pkg::NUM_REGS];
    cbbsu_pkg::t_flags r_flags;

    // result stage
    logic        r_out_vld;
    logic [7:0]  r_result;
    logic [3:0]  r_flags_out;
    logic        r_mem_wr;
    logic [15:0] r_mem_addr;
    logic [7:0]  r_mem_wdata;

    logic              advance;
    logic              in_take;
    logic              is_mem;
    logic [2:0]        opnd_slot;
    logic [7:0]        operand;
    logic [7:0]        alu_result;
    cbbsu_pkg::t_flags alu_flags;
    logic              alu_writes;

    cbbsu_pkg::t_flags n_flags;
    logic [7:0]        n_result;
    logic              n_mem_wr;
    logic [7:0]        n_mem_wdata;
    logic              n_reg_we;
    logic [2:0]        n_reg_slot;
    logic [7:0]        n_reg_data;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_take    = i_in_valid && o_in_ready;

    assign is_mem    = (r_opcode[2:0] == cbbsu_pkg::OPND_MEM);
    assign opnd_slot = cbbsu_pkg::slot_of(r_opcode[2:0]);
    assign operand   = is_mem ? r_mem_rd : r_regs[opnd_slot];

    cbbsu_alu u_alu (
        .i_opcode  (r_opcode),
        .i_operand (operand),
        .i_flags   (r_flags),
        .o_result  (alu_result),
        .o_flags   (alu_flags),
        .o_writes  (alu_writes)
    );

    always_comb begin
        n_flags     = r_flags;
        n_result    = alu_result;
        n_mem_wr    = 1'b0;
        n_mem_wdata = 8'd0;
        n_reg_we    = 1'b0;
        n_reg_slot  = opnd_slot;
        n_reg_data  = alu_result;
        if (r_command) begin
            if (r_load_index == cbbsu_pkg::LOAD_FLAGS) begin
                n_flags  = cbbsu_pkg::t_flags'(r_load_value[7:4]);
                n_result = {r_load_value[7:4], 4'd0};
            end else begin
                n_result   = r_load_value;
                n_reg_we   = 1'b1;
                n_reg_slot = cbbsu_pkg::slot_of(r_load_index);
                n_reg_data = r_load_value;
            end
        end else begin
            n_flags = alu_flags;
            if (alu_writes) begin
                if (is_mem) begin
                    n_mem_wr    = 1'b1;
                    n_mem_wdata = alu_result;
                end else begin
                    n_reg_we = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command    <= i_command;
            r_opcode     <= i_opcode;
            r_mem_rd     <= i_mem_read_data;
            r_load_index <= i_load_index;
            r_load_value <= i_load_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cbbsu_pkg::NUM_REGS; i++) begin
                r_regs[i] <= 8'd0;
            end
            r_flags <= '0;
        end else if (advance) begin
            r_flags <= n_flags;
            if (n_reg_we) begin
                r_regs[n_reg_slot] <= n_reg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result    <= n_result;
            r_flags_out <= n_flags;
            r_mem_wr    <= n_mem_wr;
            r_mem_addr  <= {r_regs[cbbsu_pkg::SLOT_H], r_regs[cbbsu_pkg::SLOT_L]};
            r_mem_wdata <= n_mem_wdata;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_result_value   = r_result;
    assign o_flags_out      = r_flags_out;
    assign o_mem_write      = r_mem_wr;
    assign o_mem_address    = r_mem_addr;
    assign o_mem_write_data = r_mem_wdata;

endmodule
